[rtl/core/grbf_pkg.sv]
package grbf_pkg;

  localparam int MAX_KERNELS_DEF = 64;
  localparam int FRAC_BITS       = 16;
  localparam int EXP_Q           = 30;
  localparam int EXP_TERMS       = 12;
  localparam int QUEUE_DEPTH     = 2;
  localparam int COUNT_OUT_W     = 7;
  localparam int VTERM_W         = 48;
  localparam int DTERM_W         = 54;

  // exp(-1) in Q0.30 (scale 2^30)
  localparam logic [28:0] EXP_NEG_ONE = 29'd395007542;

  // request kind codes on the input channel
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_EVAL   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_APPEND,
    OP_EVAL
  } op_t;

  typedef struct packed {
    logic signed [31:0] weight;
    logic signed [31:0] amplitude;
    logic [30:0]        spread;
    logic signed [31:0] centre;
  } kernel_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] point;
    kernel_t            kern;
  } cmd_t;

  typedef struct packed {
    kernel_t            kern;
    logic signed [31:0] point;
  } kjob_t;

  typedef struct packed {
    logic signed [VTERM_W-1:0] vterm;
    logic signed [DTERM_W-1:0] dterm;
  } kres_t;

  // floor(2^32 / k) for the series divisors
  function automatic logic [32:0] recip_k(input logic [3:0] k);
    logic [32:0] r;
    unique case (k)
      4'd1:    r = 33'd4294967296;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/grbf_front.sv]
module grbf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic signed [31:0]  in_point,
  input  logic signed [31:0]  in_weight,
  input  logic signed [31:0]  in_amplitude,
  input  logic [30:0]         in_spread_sq,
  input  logic signed [31:0]  in_centre,
  input  logic                q_full,
  output logic                q_push,
  output grbf_pkg::cmd_t      q_cmd
);
  import grbf_pkg::*;

  logic hold_valid_r, hold_valid_nxt;
  cmd_t hold_cmd_r, cmd_nxt;
  logic load;

  assign in_stall = hold_valid_r && q_full;
  assign load     = in_valid && !in_stall;
  assign q_push   = hold_valid_r && !q_full;
  assign q_cmd    = hold_cmd_r;

  always_comb begin
    cmd_nxt.point            = in_point;
    cmd_nxt.kern.weight      = in_weight;
    cmd_nxt.kern.amplitude   = in_amplitude;
    cmd_nxt.kern.centre      = in_centre;
    // zero width behaves as the smallest width
    cmd_nxt.kern.spread      = (in_spread_sq == '0) ? 31'd1 : in_spread_sq;
    unique case (in_kind)
      KIND_CLEAR:  cmd_nxt.op = OP_CLEAR;
      KIND_APPEND: cmd_nxt.op = OP_APPEND;
      KIND_EVAL:   cmd_nxt.op = OP_EVAL;
      KIND_NONE:   cmd_nxt.op = OP_NONE;
    endcase
  end

  always_comb begin
    if (load) begin
      hold_valid_nxt = 1'b1;
    end else if (q_push) begin
      hold_valid_nxt = 1'b0;
    end else begin
      hold_valid_nxt = hold_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_cmd_r <= cmd_nxt;
    end
  end

endmodule

[rtl/core/grbf_queue.sv]
module grbf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  grbf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output grbf_pkg::cmd_t pop_cmd
);
  import grbf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/core/grbf_kernel_unit.sv]
module grbf_kernel_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  grbf_pkg::kjob_t job,
  output logic            done,
  output grbf_pkg::kres_t res
);
  import grbf_pkg::*;

  localparam logic [3:0] K_IDLE  = 4'd0;
  localparam logic [3:0] K_PREP  = 4'd1;
  localparam logic [3:0] K_SQ    = 4'd2;
  localparam logic [3:0] K_D1LD  = 4'd3;
  localparam logic [3:0] K_DIV   = 4'd4;
  localparam logic [3:0] K_SMUL  = 4'd5;
  localparam logic [3:0] K_SRCP  = 4'd6;
  localparam logic [3:0] K_SCOR  = 4'd7;
  localparam logic [3:0] K_DECAY = 4'd8;
  localparam logic [3:0] K_SC0   = 4'd9;
  localparam logic [3:0] K_SC1   = 4'd10;
  localparam logic [3:0] K_MSUM  = 4'd11;
  localparam logic [3:0] K_XM0   = 4'd12;
  localparam logic [3:0] K_XM1   = 4'd13;
  localparam logic [3:0] K_D2LD  = 4'd14;
  localparam logic [3:0] K_FIN   = 4'd15;

  // exponent quotient bits kept: integer part below 32 plus fraction
  localparam int QW     = FRAC_BITS + 5;
  localparam int SLOPEW = 53;
  localparam logic [SLOPEW-1:0] DMAG_CAP = SLOPEW'(1) << 52;

  logic [3:0]          st_r, st_nxt;
  kjob_t               job_r, job_nxt;
  logic [25:0]         ad_r, ad_nxt;
  logic                far_r, far_nxt, dpos_r, dpos_nxt, neg_r, neg_nxt;
  logic [63:0]         wa_r, wa_nxt;
  logic [51:0]         sq_r, sq_nxt;
  logic [46:0]         dv_rem_r, dv_rem_nxt, dv_den_r, dv_den_nxt;
  logic [52:0]         dv_sh_r, dv_sh_nxt, dv_quo_r, dv_quo_nxt;
  logic [5:0]          dv_cnt_r, dv_cnt_nxt;
  logic                dv_mode_r, dv_mode_nxt;
  logic [4:0]          n_r, n_nxt;
  logic [29:0]         f_r, f_nxt;
  logic [30:0]         term_r, term_nxt;
  logic signed [31:0]  sum_r, sum_nxt;
  logic [3:0]          k_r, k_nxt;
  logic [60:0]         p_r, p_nxt;
  logic [30:0]         t_r, t_nxt;
  logic [63:0]         rp_r, rp_nxt;
  logic [30:0]         e_r, e_nxt;
  logic [62:0]         plo_r, plo_nxt, phi_r, phi_nxt;
  logic [63:0]         m_r, m_nxt;
  logic [58:0]         xlo_r, xlo_nxt, xhi_r, xhi_nxt;
  logic [SLOPEW-1:0]   dmag_r, dmag_nxt;
  kres_t               res_r, res_nxt;
  logic                done_r, done_nxt;

  logic signed [32:0]  dx;
  logic [32:0]         ad33;
  logic [31:0]         wmag, amag;
  logic [47:0]         rem2;
  logic                dv_ge;
  logic [31:0]         q0, tq;
  logic [35:0]         qk, rr;
  logic signed [31:0]  tsgn;
  logic [59:0]         ep;
  logic [26:0]         tad;
  logic [90:0]         xs;
  logic signed [VTERM_W-1:0] vpos;
  logic signed [DTERM_W-1:0] dpos_t;

  assign done = done_r;
  assign res  = res_r;

  always_comb begin
    dx    = {job_r.point[31], job_r.point} - {job_r.kern.centre[31], job_r.kern.centre};
    ad33  = dx[32] ? (~dx + 33'sd1) : dx;
    wmag  = job_r.kern.weight[31] ? (~job_r.kern.weight + 32'd1) : job_r.kern.weight;
    amag  = job_r.kern.amplitude[31] ? (~job_r.kern.amplitude + 32'd1)
                                       : job_r.kern.amplitude;
    rem2  = {dv_rem_r, dv_sh_r[52]};
    dv_ge = (rem2 >= {1'b0, dv_den_r});
    q0    = rp_r[63:32];
    qk    = q0 * k_r;
    rr    = 36'(t_r) - qk;
    tq    = (rr >= 36'(k_r)) ? q0 + 32'd1 : q0;
    tsgn  = $signed({1'b0, tq[30:0]});
    ep    = e_r * EXP_NEG_ONE;
    tad   = {ad_r, 1'b0};
    xs    = {xhi_r, 32'd0} + 91'(xlo_r);
    vpos  = $signed(m_r[63:FRAC_BITS]);
    dpos_t = $signed({1'b0, dmag_r});
  end

  always_comb begin
    st_nxt      = st_r;
    job_nxt     = job_r;
    ad_nxt      = ad_r;
    far_nxt     = far_r;
    dpos_nxt    = dpos_r;
    neg_nxt     = neg_r;
    wa_nxt      = wa_r;
    sq_nxt      = sq_r;
    dv_rem_nxt  = dv_rem_r;
    dv_den_nxt  = dv_den_r;
    dv_sh_nxt   = dv_sh_r;
    dv_quo_nxt  = dv_quo_r;
    dv_cnt_nxt  = dv_cnt_r;
    dv_mode_nxt = dv_mode_r;
    n_nxt       = n_r;
    f_nxt       = f_r;
    term_nxt    = term_r;
    sum_nxt     = sum_r;
    k_nxt       = k_r;
    p_nxt       = p_r;
    t_nxt       = t_r;
    rp_nxt      = rp_r;
    e_nxt       = e_r;
    plo_nxt     = plo_r;
    phi_nxt     = phi_r;
    m_nxt       = m_r;
    xlo_nxt     = xlo_r;
    xhi_nxt     = xhi_r;
    dmag_nxt    = dmag_r;
    res_nxt     = res_r;
    done_nxt    = 1'b0;
    unique case (st_r)
      K_IDLE: begin
        if (start) begin
          job_nxt = job;
          st_nxt  = K_PREP;
        end
      end
      K_PREP: begin
        far_nxt  = |ad33[32:26];
        ad_nxt   = ad33[25:0];
        dpos_nxt = !dx[32] && (dx != '0);
        neg_nxt  = job_r.kern.weight[31] ^ job_r.kern.amplitude[31];
        wa_nxt   = wmag * amag;
        st_nxt   = K_SQ;
      end
      K_SQ: begin
        if (far_r) begin
          m_nxt    = '0;
          dmag_nxt = '0;
          st_nxt   = K_FIN;
        end else begin
          sq_nxt = ad_r * ad_r;
          st_nxt = K_D1LD;
        end
      end
      K_D1LD: begin
        // integer part of the exponent of 32 or more: term is zero
        if (sq_r[51:QW] >= job_r.kern.spread) begin
          m_nxt    = '0;
          dmag_nxt = '0;
          st_nxt   = K_FIN;
        end else begin
          dv_rem_nxt  = 47'(sq_r[51:QW]);
          dv_sh_nxt   = {sq_r[QW-1:0], 32'd0};
          dv_den_nxt  = 47'(job_r.kern.spread);
          dv_quo_nxt  = '0;
          dv_cnt_nxt  = 6'(QW);
          dv_mode_nxt = 1'b0;
          st_nxt      = K_DIV;
        end
      end
      K_DIV: begin
        if (dv_cnt_r != '0) begin
          dv_rem_nxt = dv_ge ? 47'(rem2 - {1'b0, dv_den_r}) : 47'(rem2);
          dv_quo_nxt = {dv_quo_r[51:0], dv_ge};
          dv_sh_nxt  = {dv_sh_r[51:0], 1'b0};
          dv_cnt_nxt = dv_cnt_r - 6'd1;
        end else if (!dv_mode_r) begin
          n_nxt    = dv_quo_r[QW-1:FRAC_BITS];
          f_nxt    = {dv_quo_r[FRAC_BITS-1:0], (EXP_Q - FRAC_BITS)'(0)};
          term_nxt = 31'd1 << EXP_Q;
          sum_nxt  = 32'sd1 <<< EXP_Q;
          k_nxt    = 4'd1;
          st_nxt   = K_SMUL;
        end else begin
          dmag_nxt = (dv_quo_r > DMAG_CAP) ? DMAG_CAP : dv_quo_r;
          st_nxt   = K_FIN;
        end
      end
      K_SMUL: begin
        p_nxt  = term_r * f_r;
        st_nxt = K_SRCP;
      end
      K_SRCP: begin
        t_nxt  = p_r[60:EXP_Q];
        rp_nxt = p_r[60:EXP_Q] * recip_k(k_r);
        st_nxt = K_SCOR;
      end
      K_SCOR: begin
        // reciprocal estimate is at most one low
        term_nxt = tq[30:0];
        sum_nxt  = k_r[0] ? sum_r - tsgn : sum_r + tsgn;
        if (k_r == 4'(EXP_TERMS)) begin
          e_nxt  = sum_nxt[31] ? '0 : sum_nxt[30:0];
          st_nxt = K_DECAY;
        end else begin
          k_nxt  = k_r + 4'd1;
          st_nxt = K_SMUL;
        end
      end
      K_DECAY: begin
        if (n_r == '0) begin
          st_nxt = K_SC0;
        end else begin
          e_nxt = 31'(ep[59:EXP_Q]);
          n_nxt = n_r - 5'd1;
        end
      end
      K_SC0: begin
        plo_nxt = wa_r[31:0] * e_r;
        st_nxt  = K_SC1;
      end
      K_SC1: begin
        phi_nxt = wa_r[63:32] * e_r;
        st_nxt  = K_MSUM;
      end
      K_MSUM: begin
        m_nxt  = 64'({phi_r, 2'b00}) + 64'(plo_r[62:EXP_Q]);
        st_nxt = K_XM0;
      end
      K_XM0: begin
        xlo_nxt = m_r[31:0] * tad;
        st_nxt  = K_XM1;
      end
      K_XM1: begin
        xhi_nxt = m_r[63:32] * tad;
        st_nxt  = K_D2LD;
      end
      K_D2LD: begin
        if (47'(xs[90:SLOPEW]) >= {job_r.kern.spread, 16'd0}) begin
          dmag_nxt = DMAG_CAP;
          st_nxt   = K_FIN;
        end else begin
          dv_rem_nxt  = 47'(xs[90:SLOPEW]);
          dv_sh_nxt   = xs[SLOPEW-1:0];
          dv_den_nxt  = {job_r.kern.spread, 16'd0};
          dv_quo_nxt  = '0;
          dv_cnt_nxt  = 6'(SLOPEW);
          dv_mode_nxt = 1'b1;
          st_nxt      = K_DIV;
        end
      end
      K_FIN: begin
        res_nxt.vterm = neg_r ? -vpos : vpos;
        res_nxt.dterm = (neg_r ^ dpos_r) ? -dpos_t : dpos_t;
        done_nxt      = 1'b1;
        st_nxt        = K_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= K_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    ad_r      <= ad_nxt;
    far_r     <= far_nxt;
    dpos_r    <= dpos_nxt;
    neg_r     <= neg_nxt;
    wa_r      <= wa_nxt;
    sq_r      <= sq_nxt;
    dv_rem_r  <= dv_rem_nxt;
    dv_den_r  <= dv_den_nxt;
    dv_sh_r   <= dv_sh_nxt;
    dv_quo_r  <= dv_quo_nxt;
    dv_cnt_r  <= dv_cnt_nxt;
    dv_mode_r <= dv_mode_nxt;
    n_r       <= n_nxt;
    f_r       <= f_nxt;
    term_r    <= term_nxt;
    sum_r     <= sum_nxt;
    k_r       <= k_nxt;
    p_r       <= p_nxt;
    t_r       <= t_nxt;
    rp_r      <= rp_nxt;
    e_r       <= e_nxt;
    plo_r     <= plo_nxt;
    phi_r     <= phi_nxt;
    m_r       <= m_nxt;
    xlo_r     <= xlo_nxt;
    xhi_r     <= xhi_nxt;
    dmag_r    <= dmag_nxt;
    res_r     <= res_nxt;
  end

endmodule

[rtl/core/grbf_back.sv]
module grbf_back #(
  parameter int MAX_KERNELS = grbf_pkg::MAX_KERNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  grbf_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_sum_value,
  output logic signed [31:0]  out_sum_slope,
  output logic                out_accepted,
  output logic [grbf_pkg::COUNT_OUT_W-1:0] out_stored_count
);
  import grbf_pkg::*;

  localparam int CNT_W  = $clog2(MAX_KERNELS + 1);
  localparam int KIDX_W = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;
  localparam int ACC_W  = DTERM_W + CNT_W + 1;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_RD   = 3'd1;
  localparam logic [2:0] B_ST   = 3'd2;
  localparam logic [2:0] B_RUN  = 3'd3;
  localparam logic [2:0] B_FIN  = 3'd4;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic hi, lo;
    hi = !v[ACC_W-1] && (|v[ACC_W-2:31]);
    lo = v[ACC_W-1] && !(&v[ACC_W-2:31]);
    if (hi) begin
      return 32'sh7fffffff;
    end else if (lo) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  kernel_t kern_mem [MAX_KERNELS];
  kernel_t kern_rd_r;

  logic [2:0]               st_r, st_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [KIDX_W-1:0]        idx_r, idx_nxt;
  logic signed [31:0]       x_r, x_nxt;
  logic signed [ACC_W-1:0]  vacc_r, vacc_nxt, dacc_r, dacc_nxt;
  logic                     mem_we;
  logic                     out_valid_r, out_free, out_load;
  logic signed [31:0]       val_r, val_nxt, slope_r, slope_nxt;
  logic                     acc_r, acc_nxt;
  logic [CNT_W-1:0]         cnt_out_r, cnt_out_nxt;
  logic                     k_start, k_done;
  kjob_t                    k_job;
  kres_t                    k_res;
  logic                     last_kernel;

  assign out_free         = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_sum_value    = val_r;
  assign out_sum_slope    = slope_r;
  assign out_accepted     = acc_r;
  assign out_stored_count = COUNT_OUT_W'(cnt_out_r);
  assign last_kernel      = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
  assign k_job.kern       = kern_rd_r;
  assign k_job.point      = x_r;

  grbf_kernel_unit u_kernel (
    .clk   (clk),
    .rst_n (rst_n),
    .start (k_start),
    .job   (k_job),
    .done  (k_done),
    .res   (k_res)
  );

  always_comb begin
    st_nxt      = st_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    x_nxt       = x_r;
    vacc_nxt    = vacc_r;
    dacc_nxt    = dacc_r;
    mem_we      = 1'b0;
    q_pop       = 1'b0;
    k_start     = 1'b0;
    out_load    = 1'b0;
    val_nxt     = '0;
    slope_nxt   = '0;
    acc_nxt     = 1'b1;
    cnt_out_nxt = count_r;
    unique case (st_r)
      B_IDLE: begin
        if (q_valid && out_free) begin
          q_pop    = 1'b1;
          out_load = 1'b1;
          unique case (q_cmd.op)
            OP_CLEAR: begin
              count_nxt   = '0;
              cnt_out_nxt = '0;
            end
            OP_APPEND: begin
              if (count_r < CNT_W'(MAX_KERNELS)) begin
                mem_we      = 1'b1;
                count_nxt   = count_r + CNT_W'(1);
                cnt_out_nxt = count_nxt;
              end else begin
                acc_nxt = 1'b0;
              end
            end
            OP_EVAL: begin
              // an empty table answers at once with zero sums
              if (count_r != '0) begin
                out_load = 1'b0;
                x_nxt    = q_cmd.point;
                idx_nxt  = '0;
                vacc_nxt = '0;
                dacc_nxt = '0;
                st_nxt   = B_RD;
              end
            end
            OP_NONE: begin
              acc_nxt = 1'b0;
            end
          endcase
        end
      end
      B_RD: begin
        st_nxt = B_ST;
      end
      B_ST: begin
        k_start = 1'b1;
        st_nxt  = B_RUN;
      end
      B_RUN: begin
        if (k_done) begin
          vacc_nxt = vacc_r + ACC_W'(k_res.vterm);
          dacc_nxt = dacc_r + ACC_W'(k_res.dterm);
          if (last_kernel) begin
            st_nxt = B_FIN;
          end else begin
            idx_nxt = idx_r + KIDX_W'(1);
            st_nxt  = B_RD;
          end
        end
      end
      B_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          val_nxt   = sat32(vacc_r);
          slope_nxt = sat32(dacc_r);
          st_nxt    = B_IDLE;
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    x_r    <= x_nxt;
    vacc_r <= vacc_nxt;
    dacc_r <= dacc_nxt;
    if (out_load) begin
      val_r     <= val_nxt;
      slope_r   <= slope_nxt;
      acc_r     <= acc_nxt;
      cnt_out_r <= cnt_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      kern_mem[count_r[KIDX_W-1:0]] <= q_cmd.kern;
    end
    kern_rd_r <= kern_mem[idx_r];
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_KERNELS))
    else $error("kernel count above table size");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    k_done |-> st_r == B_RUN)
    else $error("kernel result outside evaluate loop");

  a_idx_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_RUN || st_r == B_ST) |-> CNT_W'(idx_r) < count_r)
    else $error("kernel index past stored count");

  a_start_then_run: assert property (@(posedge clk) disable iff (!rst_n)
    k_start |=> st_r == B_RUN && !k_done)
    else $error("kernel start not followed by wait");
`endif

endmodule

[rtl/core/gaussian_rbf_expansion_eval.sv]
// Channel  Ports                                          Direction  Accept
// in       in_valid/in_stall, in_kind .. in_centre        into block valid && !stall
// out      out_valid/out_stall, out_sum_value .. count    from block valid && !stall
//
// Clear, append and unknown requests: front hold register, queue, output register;
// one per cycle sustained while out_stall is low. Evaluate: per stored kernel in turn,
// the kernel unit's bit-serial divider (21 + 53 steps), series multiplier and n decay
// steps (n = integer part of (x-c)^2/s, 0..31); a kernel with n >= 32 skips them.
// A two-entry queue separates intake from execution; intake stalls only when it is full.
// Reset (rst_n low, synchronous) empties the table and the queue; table memory is not cleared.
module gaussian_rbf_expansion_eval #(
  parameter int MAX_KERNELS = grbf_pkg::MAX_KERNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic signed [31:0]  in_point,
  input  logic signed [31:0]  in_weight,
  input  logic signed [31:0]  in_amplitude,
  input  logic [30:0]         in_spread_sq,
  input  logic signed [31:0]  in_centre,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_sum_value,
  output logic signed [31:0]  out_sum_slope,
  output logic                out_accepted,
  output logic [grbf_pkg::COUNT_OUT_W-1:0] out_stored_count
);
  import grbf_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic q_push, q_full, q_pop, q_valid;

  grbf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_point     (in_point),
    .in_weight    (in_weight),
    .in_amplitude (in_amplitude),
    .in_spread_sq (in_spread_sq),
    .in_centre    (in_centre),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  grbf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_cmd   (pop_cmd)
  );

  grbf_back #(
    .MAX_KERNELS (MAX_KERNELS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sum_value    (out_sum_value),
    .out_sum_slope    (out_sum_slope),
    .out_accepted     (out_accepted),
    .out_stored_count (out_stored_count)
  );

endmodule

[tb/gaussian_rbf_expansion_eval_tb.sv]
module gaussian_rbf_expansion_eval_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import grbf_pkg::*;

  localparam int TABLE_SIZE = 64;
  localparam int IDLE_LIMIT = 80000;
  localparam int HOLD_CYCLES = 400;
  localparam longint unsigned SLOPE_CAP = 64'd1 << 52;

  typedef struct {
    logic signed [31:0] sum_value;
    logic signed [31:0] sum_slope;
    logic               accepted;
    logic [6:0]         stored_count;
  } rbf_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = KIND_CLEAR;
  logic signed [31:0] in_point = '0;
  logic signed [31:0] in_weight = '0;
  logic signed [31:0] in_amplitude = '0;
  logic [30:0] in_spread_sq = 31'd1;
  logic signed [31:0] in_centre = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_sum_value;
  logic signed [31:0] out_sum_slope;
  logic out_accepted;
  logic [COUNT_OUT_W-1:0] out_stored_count;

  // shadow of the kernel table
  logic signed [31:0] tbl_weight[TABLE_SIZE];
  logic signed [31:0] tbl_amp[TABLE_SIZE];
  logic [30:0]        tbl_spread[TABLE_SIZE];
  logic signed [31:0] tbl_centre[TABLE_SIZE];
  int tbl_count = 0;

  rbf_result_t pending_results[$];
  int mismatches = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit hold_req = 0;
  bit no_idle = 0;

  always #6 clk = ~clk;

  gaussian_rbf_expansion_eval i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_point(in_point), .in_weight(in_weight),
    .in_amplitude(in_amplitude), .in_spread_sq(in_spread_sq), .in_centre(in_centre),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sum_value(out_sum_value), .out_sum_slope(out_sum_slope),
    .out_accepted(out_accepted), .out_stored_count(out_stored_count)
  );

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void expansion_at(input logic signed [31:0] x,
                                       output logic signed [31:0] val,
                                       output logic signed [31:0] slope);
    longint d, vsum, dsum, series;
    longint unsigned ad, s, q, n, f, term, e, wa, m, vmag, dmag;
    logic [127:0] wide;
    bit neg, dneg;
    vsum = 0;
    dsum = 0;
    for (int i = 0; i < tbl_count; i++) begin
      d = longint'(x) - longint'(tbl_centre[i]);
      ad = d < 0 ? -d : d;
      s = tbl_spread[i] == 0 ? 64'd1 : 64'(tbl_spread[i]);
      q = (ad * ad) / s;
      n = q >> FRAC_BITS;
      if (n >= 32) continue;
      f = (q & 64'hffff) << (EXP_Q - FRAC_BITS);
      series = 64'sd1 << EXP_Q;
      term = 64'd1 << EXP_Q;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * f) >> EXP_Q) / k;
        if (k % 2) series -= longint'(term);
        else series += longint'(term);
      end
      e = series < 0 ? 64'd0 : series;
      for (int j = 0; j < n; j++) e = (e * 64'(EXP_NEG_ONE)) >> EXP_Q;
      wa = (tbl_weight[i] < 0 ? -longint'(tbl_weight[i]) : longint'(tbl_weight[i]))
         * (tbl_amp[i] < 0 ? -longint'(tbl_amp[i]) : longint'(tbl_amp[i]));
      wide = ({64'd0, wa} * {64'd0, e}) >> EXP_Q;
      m = wide[63:0];
      vmag = m >> FRAC_BITS;
      wide = (({64'd0, m} * {64'd0, 2 * ad}) / {64'd0, s}) >> FRAC_BITS;
      dmag = (wide > 128'(SLOPE_CAP)) ? SLOPE_CAP : wide[63:0];
      neg = (tbl_weight[i] < 0) != (tbl_amp[i] < 0);
      dneg = neg != (d > 0);
      vsum += neg ? -longint'(vmag) : longint'(vmag);
      dsum += dneg ? -longint'(dmag) : longint'(dmag);
    end
    val = clamp32(vsum);
    slope = clamp32(dsum);
  endfunction

  function automatic rbf_result_t apply_request(input logic [1:0] kind,
      input logic signed [31:0] x, input logic signed [31:0] w,
      input logic signed [31:0] a, input logic [30:0] s, input logic signed [31:0] c);
    rbf_result_t r;
    r.sum_value = '0;
    r.sum_slope = '0;
    r.accepted = 1'b1;
    case (kind)
      KIND_CLEAR: tbl_count = 0;
      KIND_APPEND: begin
        if (tbl_count < TABLE_SIZE) begin
          tbl_weight[tbl_count] = w;
          tbl_amp[tbl_count] = a;
          tbl_spread[tbl_count] = s;
          tbl_centre[tbl_count] = c;
          tbl_count++;
        end else begin
          r.accepted = 1'b0;
        end
      end
      KIND_EVAL: expansion_at(x, r.sum_value, r.sum_slope);
      default: r.accepted = 1'b0;
    endcase
    r.stored_count = tbl_count[6:0];
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic send_item(input logic [1:0] kind, input logic signed [31:0] x,
      input logic signed [31:0] w, input logic signed [31:0] a,
      input logic [30:0] s, input logic signed [31:0] c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_point <= x;
    in_weight <= w;
    in_amplitude <= a;
    in_spread_sq <= s;
    in_centre <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_request(kind, x, w, a, s, c));
    items_sent++;
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_kernel(input logic signed [31:0] w, input logic signed [31:0] a,
                             input logic [30:0] s, input logic signed [31:0] c);
    send_item(KIND_APPEND, $urandom, w, a, s, c);
  endtask

  task automatic send_eval(input logic signed [31:0] x);
    send_item(KIND_EVAL, x, $urandom, $urandom, 31'($urandom), $urandom);
  endtask

  task automatic test_directed();
    send_item(KIND_CLEAR, '0, '0, '0, 31'd1, '0);
    send_eval(32'sh7fffffff);                     // empty table
    send_item(KIND_NONE, $urandom, $urandom, $urandom, 31'($urandom), $urandom);
    send_kernel(32'sh7fffffff, 32'sh7fffffff, 31'd1, '0);
    send_eval('0);                                // saturates the value sum
    send_eval(32'sh00000100);
    send_kernel(32'sh80000000, 32'sh80000000, 31'd0, 32'sh00010000);  // zero width
    send_eval(32'sh00010000);
    send_eval(32'sh00010080);
    send_kernel(32'sh80000000, 32'sh7fffffff, 31'h7fffffff, 32'sh80000000);
    send_eval(32'sh80000000);
    send_eval(32'sh7fffffff);                     // far from every centre
    send_kernel(32'sh00010000, 32'sh00010000, 31'h00010000, 32'sh7fffffff);
    send_eval(32'sh7ffc0000);
    send_eval(32'sh7fffffff);
    send_item(KIND_NONE, '0, '0, '0, '0, '0);
    send_item(KIND_CLEAR, '1, '1, '1, '1, '1);
    send_eval('1);
    wait_drained();
  endtask

  task automatic test_full_table();
    send_item(KIND_CLEAR, '0, '0, '0, 31'd1, '0);
    for (int i = 0; i < TABLE_SIZE + 2; i++)
      send_kernel($urandom, $urandom, 31'h00400000 + 31'($urandom_range(0, 31'h00ffffff)),
                  32'sh00100000 * $urandom_range(0, 8) - 32'sh00400000);
    send_eval($urandom_range(0, 32'h00080000) - 32'sh00040000);
    send_eval($urandom);
    send_item(KIND_CLEAR, '0, '0, '0, 31'd1, '0);
    wait_drained();
  endtask

  // mostly table builds followed by evaluations near the centres
  task automatic test_random(input int upto);
    int nk, ne, pick;
    logic signed [31:0] c;
    logic [30:0] s;
    while (items_sent < upto) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_item(2'($urandom), $urandom, $urandom, $urandom, 31'($urandom), $urandom);
      end else begin
        if ($urandom_range(0, 3) != 0) send_item(KIND_CLEAR, $urandom, $urandom,
                                                 $urandom, 31'($urandom), $urandom);
        nk = ($urandom_range(0, 60) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 5);
        for (int i = 0; i < nk; i++) begin
          case ($urandom_range(0, 3))
            0: s = 31'($urandom);
            1: s = 31'($urandom_range(0, 255));
            default: s = 31'($urandom_range(31'h00001000, 31'h01000000));
          endcase
          c = $urandom;
          send_kernel($urandom, $urandom, s, c);
        end
        ne = $urandom_range(1, 4);
        for (int i = 0; i < ne && items_sent < upto + 8; i++) begin
          if (tbl_count > 0 && $urandom_range(0, 3) != 0)
            send_eval(tbl_centre[$urandom_range(0, tbl_count - 1)]
                      + $signed($urandom_range(0, 32'h00080000)) - 32'sh00040000);
          else
            send_eval($urandom);
        end
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    no_idle = 1;
    for (int i = 0; i < 12; i++)
      send_item($urandom_range(0, 1) ? KIND_APPEND : KIND_NONE,
                $urandom, $urandom, $urandom, 31'($urandom), $urandom);
    send_item(KIND_CLEAR, '0, '0, '0, 31'd1, '0);
    no_idle = 0;
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    no_idle = 1;
    test_random(300);
    no_idle = 0;
    test_random(1100);
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    rbf_result_t want;
    int gap;
    forever begin
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 0;
      end else begin
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && rst_n)) @(posedge clk);
      if (pending_results.size() == 0) begin
        report("unexpected result", longint'(out_sum_value), longint'(0));
      end else begin
        want = pending_results.pop_front();
        if (out_sum_value !== want.sum_value)
          report("sum_value", longint'(out_sum_value), longint'(want.sum_value));
        if (out_sum_slope !== want.sum_slope)
          report("sum_slope", longint'(out_sum_slope), longint'(want.sum_slope));
        if (out_accepted !== want.accepted)
          report("accepted", longint'(out_accepted), longint'(want.accepted));
        if (out_stored_count !== want.stored_count)
          report("stored_count", longint'(out_stored_count), longint'(want.stored_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[filelist.f]
rtl/core/grbf_pkg.sv
rtl/core/grbf_front.sv
rtl/core/grbf_queue.sv
rtl/core/grbf_kernel_unit.sv
rtl/core/grbf_back.sv
rtl/core/gaussian_rbf_expansion_eval.sv
tb/gaussian_rbf_expansion_eval_tb.sv
